// File: design/spreadsheet_serial_to_datetime_assert.svh
// assertion macros for the spreadsheet serial to date and time converter
`ifndef SPREADSHEET_SERIAL_TO_DATETIME_ASSERT_SVH
`define SPREADSHEET_SERIAL_TO_DATETIME_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SSDT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssdt assertion failed");
// next-cycle implication
`define SSDT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssdt assertion failed");
`else
`define SSDT_ASSERT_IMP(label, clk, rst, ante, cons)
`define SSDT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/ssdt_pkg.sv
// shared types, constants and tables for the serial to date and time converter
package ssdt_pkg;

  typedef struct packed {
    logic [21:0] day_number;
    logic [31:0] day_fraction;
  } serial_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second_of_minute;
  } stamp_t;

  localparam int NUM_STAGES = 10;
  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // day number handling
  localparam logic [21:0] DAY_NUMBER_MAX = 22'd2958465;
  localparam logic [21:0] BOGUS_LEAP_DAY = 22'd60;
  localparam logic [21:0] FIRST_SHIFTED  = 22'd61;
  // era base offset minus the 1970 offset (719468 - 25567)
  localparam logic [21:0] ERA_BASE_SHIFT = 22'd693901;

  localparam longint unsigned DaysPerEra = 64'd146097;
  localparam logic [21:0] DAYS_PER_ERA    = 22'(DaysPerEra);
  localparam logic [17:0] DAYS_PER_ERA_M1 = 18'(DaysPerEra - 64'd1);

  // reciprocals for exact division by constants: q = (x * ceil(2^k / d)) >> k,
  // exact while 2^k >= xmax * d
  localparam int ERA_SHIFT = 40;
  localparam logic [22:0] ERA_RECIP =
    23'(((64'd1 << ERA_SHIFT) + DaysPerEra - 64'd1) / DaysPerEra);
  localparam int Q1460_SHIFT = 28;
  localparam logic [17:0] Q1460_RECIP = 18'(((64'd1 << Q1460_SHIFT) + 64'd1459) / 64'd1460);
  localparam int Q36524_SHIFT = 33;
  localparam logic [17:0] Q36524_RECIP =
    18'(((64'd1 << Q36524_SHIFT) + 64'd36523) / 64'd36524);
  localparam int Q365_SHIFT = 26;
  localparam logic [17:0] Q365_RECIP = 18'(((64'd1 << Q365_SHIFT) + 64'd364) / 64'd365);
  localparam int Q100_SHIFT = 16;
  localparam logic [9:0] Q100_RECIP = 10'(((64'd1 << Q100_SHIFT) + 64'd99) / 64'd100);
  localparam int Q153_SHIFT = 19;
  localparam logic [11:0] Q153_RECIP = 12'(((64'd1 << Q153_SHIFT) + 64'd152) / 64'd153);
  localparam int Q3600_SHIFT = 29;
  localparam logic [17:0] Q3600_RECIP =
    18'(((64'd1 << Q3600_SHIFT) + 64'd3599) / 64'd3600);
  localparam int Q60_SHIFT = 18;
  localparam logic [12:0] Q60_RECIP = 13'(((64'd1 << Q60_SHIFT) + 64'd59) / 64'd60);

  localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;
  // 86400 = 675 * 128
  localparam logic [9:0] SECONDS_ODD_FACTOR = 10'd675;

  // first day of year (march-based) for each shifted month, (153 * mp + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: design/ssdt_date.sv
// date datapath: day number to year, month and day over ten pipeline stages
module ssdt_date (
  input  logic                clk,
  input  logic [21:0]         day_number,
  input  ssdt_pkg::stage_en_t en,
  output logic [13:0]         year,
  output logic [3:0]          month,
  output logic [4:0]          day_of_month
);
  import ssdt_pkg::*;

  logic [21:0] sat;
  logic [21:0] z_next;
  logic [21:0] s0_z;

  logic [44:0] era_prod;
  logic [21:0] s1_z;
  logic [4:0]  s1_era;

  logic [21:0] era_days;
  logic [17:0] s2_doe;
  logic [4:0]  s2_era;

  logic [35:0] p1460;
  logic [35:0] p36524;
  logic [17:0] s3_doe;
  logic [6:0]  s3_q1460;
  logic [2:0]  s3_q36524;
  logic        s3_full;
  logic [4:0]  s3_era;

  logic [17:0] t_next;
  logic [17:0] s4_t;
  logic [17:0] s4_doe;
  logic [4:0]  s4_era;

  logic [35:0] p365;
  logic [8:0]  s5_yoe;
  logic [17:0] s5_doe;
  logic [4:0]  s5_era;

  logic [18:0] p100;
  logic [1:0]  s6_y100;
  logic [17:0] s6_y365;
  logic [8:0]  s6_yoe;
  logic [17:0] s6_doe;
  logic [4:0]  s6_era;

  logic [17:0] year_days;
  logic [8:0]  s7_doy;
  logic [8:0]  s7_yoe;
  logic [4:0]  s7_era;

  logic [10:0] mp_num;
  logic [22:0] p153;
  logic [3:0]  s8_mp;
  logic [8:0]  s8_doy;
  logic [8:0]  s8_yoe;
  logic [4:0]  s8_era;

  logic [4:0]  dom_next;
  logic [3:0]  month_next;
  logic [13:0] year_next;

  // saturate and fold in the bogus leap day
  always_comb begin
    sat = (day_number > DAY_NUMBER_MAX) ? DAY_NUMBER_MAX : day_number;
    priority if (sat >= FIRST_SHIFTED) begin
      z_next = sat + ERA_BASE_SHIFT - 22'd2;
    end else if (sat == BOGUS_LEAP_DAY) begin
      z_next = ERA_BASE_SHIFT + 22'd58;
    end else begin
      z_next = sat + ERA_BASE_SHIFT - 22'd1;
    end
  end

  assign era_prod  = 45'(s0_z) * 45'(ERA_RECIP);
  assign era_days  = 22'(s1_era) * DAYS_PER_ERA;
  assign p1460     = 36'(s2_doe) * 36'(Q1460_RECIP);
  assign p36524    = 36'(s2_doe) * 36'(Q36524_RECIP);
  assign t_next    = s3_doe - 18'(s3_q1460) + 18'(s3_q36524) - 18'(s3_full);
  assign p365      = 36'(s4_t) * 36'(Q365_RECIP);
  assign p100      = 19'(s5_yoe) * 19'(Q100_RECIP);
  assign year_days = s6_y365 + 18'(s6_yoe[8:2]) - 18'(s6_y100);
  assign mp_num    = 11'(s7_doy) * 11'd5 + 11'd2;
  assign p153      = 23'(mp_num) * 23'(Q153_RECIP);

  always_comb begin
    dom_next   = 5'(s8_doy - month_start(s8_mp) + 9'd1);
    month_next = (s8_mp < 4'd10) ? s8_mp + 4'd3 : s8_mp - 4'd9;
    year_next  = 14'(s8_yoe) + 14'(s8_era) * 14'd400 + 14'(month_next <= 4'd2);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_z <= z_next;
    end
    if (en[1]) begin
      s1_z   <= s0_z;
      s1_era <= era_prod[ERA_SHIFT +: 5];
    end
    if (en[2]) begin
      s2_doe <= 18'(s1_z - era_days);
      s2_era <= s1_era;
    end
    if (en[3]) begin
      s3_doe    <= s2_doe;
      s3_q1460  <= p1460[Q1460_SHIFT +: 7];
      s3_q36524 <= p36524[Q36524_SHIFT +: 3];
      s3_full   <= (s2_doe == DAYS_PER_ERA_M1);
      s3_era    <= s2_era;
    end
    if (en[4]) begin
      s4_t   <= t_next;
      s4_doe <= s3_doe;
      s4_era <= s3_era;
    end
    if (en[5]) begin
      s5_yoe <= p365[Q365_SHIFT +: 9];
      s5_doe <= s4_doe;
      s5_era <= s4_era;
    end
    if (en[6]) begin
      s6_y100 <= p100[Q100_SHIFT +: 2];
      s6_y365 <= 18'(s5_yoe) * 18'd365;
      s6_yoe  <= s5_yoe;
      s6_doe  <= s5_doe;
      s6_era  <= s5_era;
    end
    if (en[7]) begin
      s7_doy <= 9'(s6_doe - year_days);
      s7_yoe <= s6_yoe;
      s7_era <= s6_era;
    end
    if (en[8]) begin
      s8_mp  <= p153[Q153_SHIFT +: 4];
      s8_doy <= s7_doy;
      s8_yoe <= s7_yoe;
      s8_era <= s7_era;
    end
    if (en[9]) begin
      year         <= year_next;
      month        <= month_next;
      day_of_month <= dom_next;
    end
  end

endmodule

// File: design/ssdt_time.sv
// time datapath: day fraction to rounded hour, minute and second
module ssdt_time #(
  parameter int FRACTION_BITS = 32
) (
  input  logic                clk,
  input  logic [31:0]         day_fraction,
  input  ssdt_pkg::stage_en_t en,
  output logic [4:0]          hour,
  output logic [5:0]          minute,
  output logic [5:0]          second_of_minute
);
  import ssdt_pkg::*;

  localparam int DLY = NUM_STAGES - 6;
  localparam int SecShift = FRACTION_BITS - 7;
  localparam logic [42:0] HALF = 43'd1 << (FRACTION_BITS - 8);
  localparam logic [31:0] FRAC_MASK =
    (FRACTION_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << FRACTION_BITS) - 64'd1);

  logic [41:0] s0_prod;
  logic [42:0] rounded;
  logic [42:0] shifted;
  logic [16:0] raw;
  logic [16:0] s1_secs;
  logic [34:0] p3600;
  logic [16:0] s2_secs;
  logic [4:0]  s2_hour;
  logic [11:0] s3_rem;
  logic [4:0]  s3_hour;
  logic [24:0] p60;
  logic [11:0] s4_rem;
  logic [5:0]  s4_minute;
  logic [4:0]  s4_hour;
  logic [16:0] s5_hms;
  logic [16:0] dly [DLY];

  assign rounded = 43'(s0_prod) + HALF;
  assign shifted = rounded >> SecShift;
  assign raw     = shifted[16:0];
  assign p3600   = 35'(s1_secs) * 35'(Q3600_RECIP);
  assign p60     = 25'(s3_rem) * 25'(Q60_RECIP);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_prod <= 42'(day_fraction & FRAC_MASK) * 42'(SECONDS_ODD_FACTOR);
    end
    if (en[1]) begin
      // a full-day round wraps to midnight
      s1_secs <= (raw >= SECONDS_PER_DAY) ? raw - SECONDS_PER_DAY : raw;
    end
    if (en[2]) begin
      s2_secs <= s1_secs;
      s2_hour <= p3600[Q3600_SHIFT +: 5];
    end
    if (en[3]) begin
      s3_rem  <= 12'(s2_secs - 17'(s2_hour) * 17'd3600);
      s3_hour <= s2_hour;
    end
    if (en[4]) begin
      s4_rem    <= s3_rem;
      s4_minute <= p60[Q60_SHIFT +: 6];
      s4_hour   <= s3_hour;
    end
    if (en[5]) begin
      s5_hms <= {s4_hour, s4_minute, 6'(s4_rem - 12'(s4_minute) * 12'd60)};
    end
    for (int k = 0; k < DLY; k++) begin
      if (en[6 + k]) begin
        dly[k] <= (k == 0) ? s5_hms : dly[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign {hour, minute, second_of_minute} = dly[DLY-1];

endmodule

// File: design/spreadsheet_serial_to_datetime.sv
// Spreadsheet 1900-system serial to calendar date and time of day. One beat on
// the serial channel (whole day number plus unsigned Q0.FRACTION_BITS day
// fraction) gives one beat on the stamp channel with year, month, day, hour,
// minute and second. The block is a ten-stage pipeline with at most two constant
// multiplies per stage: it takes a new beat every cycle unless back pressure has
// filled it, and each result passes through the stage registers in order to the
// stamp side, held back while the stamp side holds ready low. Stalls collapse
// bubbles stage by stage, so serial_ready drops only when all ten stages hold
// a result. Day 60 (the non-existent 1900-02-29) reads as Feb 28, days above
// 2958465 saturate to 9999-12-31, and a fraction that rounds to a full day
// reads as 00:00:00 on the same date.
`include "spreadsheet_serial_to_datetime_assert.svh"

module spreadsheet_serial_to_datetime #(
  parameter int FRACTION_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              serial_valid,
  output logic              serial_ready,
  input  ssdt_pkg::serial_t serial,
  output logic              stamp_valid,
  input  logic              stamp_ready,
  output ssdt_pkg::stamp_t  stamp
);
  import ssdt_pkg::*;

  // per-stage valid bits and advance enables
  logic [NUM_STAGES-1:0] v;
  stage_en_t             en;

  // stamp field range flags for the checks below
  logic                  date_in_range;
  logic                  time_in_range;

  // a stage may load when it is empty or its content moves on
  always_comb begin
    en[NUM_STAGES-1] = !v[NUM_STAGES-1] || stamp_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= serial_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign serial_ready = en[0];
  assign stamp_valid  = v[NUM_STAGES-1];

  // calendar date path
  ssdt_date u_date (
    .clk          (clk),
    .day_number   (serial.day_number),
    .en           (en),
    .year         (stamp.year),
    .month        (stamp.month),
    .day_of_month (stamp.day_of_month)
  );

  // time of day path, padded to the same depth
  ssdt_time #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_time (
    .clk              (clk),
    .day_fraction     (serial.day_fraction),
    .en               (en),
    .hour             (stamp.hour),
    .minute           (stamp.minute),
    .second_of_minute (stamp.second_of_minute)
  );

  assign date_in_range = stamp.month >= 4'd1 && stamp.month <= 4'd12 &&
                         stamp.day_of_month >= 5'd1;
  assign time_in_range = stamp.hour <= 5'd23 && stamp.minute <= 6'd59 &&
                         stamp.second_of_minute <= 6'd59;

  // back pressure only when every stage is occupied
  `SSDT_ASSERT_IMP(a_ready_only_full, clk, rst, !serial_ready, &v)
  // an accepted beat lands in the first stage
  `SSDT_ASSERT_NXT(a_accept_loads, clk, rst, serial_valid && serial_ready, v[0])
  // date fields stay in calendar range
  `SSDT_ASSERT_IMP(a_date_range, clk, rst, stamp_valid, date_in_range)
  // time fields stay in range after the midnight wrap
  `SSDT_ASSERT_IMP(a_time_range, clk, rst, stamp_valid, time_in_range)

endmodule

// File: tb/ssdt_checker.sv
// checker for the serial to date and time converter: predicts each stamp and compares
`timescale 1ns / 100ps

module ssdt_checker #(
  parameter int FRACTION_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              serial_valid,
  input  logic              serial_ready,
  input  ssdt_pkg::serial_t serial,
  input  logic              stamp_valid,
  input  logic              stamp_ready,
  input  ssdt_pkg::stamp_t  stamp,
  output int                failures,
  output int                pending
);

  import ssdt_pkg::*;

  localparam int unsigned LAST_DAY      = 2958465;
  localparam int unsigned ERA_LENGTH    = 146097;
  localparam longint unsigned DAY_SECS  = 86400;

  stamp_t expected_stamps[$];
  int     fail_count = 0;

  assign failures = fail_count;

  // civil date from the 1900-system day number, time of day from the fraction
  function automatic stamp_t serial_to_stamp(input serial_t s);
    int unsigned     day, z, era, doe, yoe, doy, mp, d, m, y;
    longint unsigned frac, secs;
    stamp_t          r;
    day = s.day_number;
    if (day > LAST_DAY) day = LAST_DAY;
    // shift to a day count from 0000-03-01; day 60 is the fake feb 29
    if (day >= 61) z = day + 693899;
    else if (day == 60) z = 693959;
    else z = day + 693900;
    era = z / ERA_LENGTH;
    doe = z - era * ERA_LENGTH;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    y   = yoe + era * 400;
    if (m <= 2) y = y + 1;
    frac = longint'(s.day_fraction);
    if (FRACTION_BITS < 64) frac = frac & ((64'd1 << FRACTION_BITS) - 64'd1);
    // fraction * 86400 rounded half up, with 86400 = 675 << 7
    secs = (frac * 675 + (64'd1 << (FRACTION_BITS - 8))) >> (FRACTION_BITS - 7);
    if (secs >= DAY_SECS) secs = secs - DAY_SECS;
    r.year             = 14'(y);
    r.month            = 4'(m);
    r.day_of_month     = 5'(d);
    r.hour             = 5'(secs / 3600);
    r.minute           = 6'((secs % 3600) / 60);
    r.second_of_minute = 6'(secs % 60);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    stamp_t want;
    if (!rst) begin
      if (serial_valid && serial_ready) begin
        expected_stamps.insert(expected_stamps.size(), serial_to_stamp(serial));
      end
      if (stamp_valid && stamp_ready) begin
        if (expected_stamps.size() == 0) begin
          $error("stamp beat with nothing expected");
          fail_count++;
        end else begin
          want = expected_stamps.pop_front();
          check_field("year", want.year, stamp.year);
          check_field("month", want.month, stamp.month);
          check_field("day_of_month", want.day_of_month, stamp.day_of_month);
          check_field("hour", want.hour, stamp.hour);
          check_field("minute", want.minute, stamp.minute);
          check_field("second_of_minute", want.second_of_minute, stamp.second_of_minute);
        end
      end
    end
    pending <= expected_stamps.size();
  end

endmodule

// File: tb/spreadsheet_serial_to_datetime_tb.sv
// testbench top for the serial to date and time converter: stimulus, flow control, verdict
`timescale 1ns / 100ps

module spreadsheet_serial_to_datetime_tb;

  import ssdt_pkg::*;

  localparam int unsigned LAST_DAY    = 2958465;
  localparam int          HOLD_CYCLES = 150;   // long receiver hold-off in the pressure phase
  localparam int          PHASE_BEATS = 190;   // random beats per phase

  typedef enum logic [2:0] {
    PH_FREE,            // no idling on either side
    PH_SENDER_IDLE,     // sender idle 80 percent
    PH_RECEIVER_STALL,  // receiver stalls 80 percent
    PH_BOTH,            // both idle/stall 29 percent
    PH_PRESSURE         // receiver holds off while sender keeps offering
  } phase_e;

  logic    clk;
  logic    rst          = 1'b1;
  logic    serial_valid = 1'b0;
  logic    serial_ready;
  serial_t serial       = '0;
  logic    stamp_valid;
  logic    stamp_ready  = 1'b0;
  stamp_t  stamp;

  phase_e  phase        = PH_FREE;
  int      hold_count   = 0;
  int      failures;
  int      pending;

  // sender idle percentage, set by the stimulus process for each phase
  int      sender_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  spreadsheet_serial_to_datetime u_dut (
    .clk          (clk),
    .rst          (rst),
    .serial_valid (serial_valid),
    .serial_ready (serial_ready),
    .serial       (serial),
    .stamp_valid  (stamp_valid),
    .stamp_ready  (stamp_ready),
    .stamp        (stamp)
  );

  ssdt_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .serial_valid (serial_valid),
    .serial_ready (serial_ready),
    .serial       (serial),
    .stamp_valid  (stamp_valid),
    .stamp_ready  (stamp_ready),
    .stamp        (stamp),
    .failures     (failures),
    .pending      (pending)
  );

  function automatic int stall_pct(input phase_e p);
    unique case (p)
      PH_RECEIVER_STALL: return 80;
      PH_BOTH:           return 29;
      default:           return 0;
    endcase
  endfunction

  // receiver side: random stalls per phase, plus one long hold-off so the
  // pipeline fills and serial_ready drops
  always @(posedge clk) begin
    if (rst) begin
      stamp_ready <= 1'b0;
      hold_count  <= 0;
    end else if (phase == PH_PRESSURE && hold_count < HOLD_CYCLES) begin
      stamp_ready <= 1'b0;
      hold_count  <= hold_count + 1;
    end else begin
      stamp_ready <= ($urandom_range(99) >= stall_pct(phase));
    end
  end

  // one beat on the serial channel, with random idle cycles ahead of it
  task automatic send_serial(input serial_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      serial_valid <= 1'b0;
      @(posedge clk);
    end
    serial_valid <= 1'b1;
    serial       <= item;
    do @(posedge clk); while (!serial_ready);
  endtask

  // day numbers biased toward the interesting regions
  function automatic logic [21:0] pick_day();
    unique case ($urandom_range(9))
      0:       return 22'($urandom_range(400));                  // around 1900
      1:       return 22'($urandom);                             // full width, saturation
      2:       return 22'($urandom_range(LAST_DAY, LAST_DAY - 400)); // near 9999
      3:       return 22'($urandom_range(62, 58));               // fake leap day
      default: return 22'($urandom_range(LAST_DAY));
    endcase
  endfunction

  // fractions biased toward rounding ties and the full-day wrap
  function automatic logic [31:0] pick_fraction();
    unique case ($urandom_range(7))
      0:       return 32'($urandom_range(255)) << 24;            // odd multiples tie
      1:       return 32'hFFFF_0000 | 32'($urandom_range(16'hFFFF)); // near midnight
      2:       return 32'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    serial_t directed[$];
    phase_e  order[5];
    serial_t item;

    order = '{PH_FREE, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH, PH_PRESSURE};

    // day zero, first days, the fake leap day and its neighbors
    directed.insert(directed.size(), {22'd0,       32'h0000_0000});
    directed.insert(directed.size(), {22'd1,       32'h0000_0001});
    directed.insert(directed.size(), {22'd59,      32'h8000_0000});
    directed.insert(directed.size(), {22'd60,      32'h4000_0000});
    directed.insert(directed.size(), {22'd61,      32'hC000_0000});
    directed.insert(directed.size(), {22'd366,     32'h2AAA_AAAB});
    // leap year 2000 around feb 29 / mar 1, and mar 1 of the non-leap 2100
    directed.insert(directed.size(), {22'd36585,   32'h1234_5678});
    directed.insert(directed.size(), {22'd36586,   32'h8765_4321});
    directed.insert(directed.size(), {22'd73110,   32'h5555_5555});
    // last valid day and saturation above it: all ones and alternating bit patterns
    directed.insert(directed.size(), {22'd2958465, 32'hFFFF_9EE8});
    directed.insert(directed.size(), {22'd2958466, 32'h0000_0000});
    directed.insert(directed.size(), {22'h3F_FFFF, 32'hFFFF_FFFF});
    directed.insert(directed.size(), {22'h2A_AAAA, 32'hAAAA_AAAA});
    directed.insert(directed.size(), {22'h15_5555, 32'h5555_5555});
    // rounding ties (exact half second) round up; the last value lies just below a tie
    directed.insert(directed.size(), {22'd40000,   32'h0100_0000});
    directed.insert(directed.size(), {22'd40001,   32'h0300_0000});
    directed.insert(directed.size(), {22'd40002,   32'h00FF_FFFF});
    // rounding to a full day wraps to midnight on the same date; the last value stays just below
    directed.insert(directed.size(), {22'd45000,   32'hFFFF_9EE9});
    directed.insert(directed.size(), {22'd45001,   32'hFFFF_FFFF});
    directed.insert(directed.size(), {22'd45002,   32'hFFFF_9EE8});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_serial(directed[i]);

    foreach (order[p]) begin
      phase <= order[p];
      sender_idle_pct = (order[p] == PH_SENDER_IDLE) ? 80 :
                        (order[p] == PH_BOTH)        ? 29 : 0;
      repeat (PHASE_BEATS) begin
        item.day_number   = pick_day();
        item.day_fraction = pick_fraction();
        send_serial(item);
      end
    end
    serial_valid <= 1'b0;

    // drain, then keep watching for stray beats
    do @(posedge clk); while (pending != 0);
    repeat (3 * ssdt_pkg::NUM_STAGES) @(posedge clk);

    if (failures == 0) begin
      $display("spreadsheet_serial_to_datetime: match");
    end else begin
      $display("spreadsheet_serial_to_datetime: mismatch");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("spreadsheet_serial_to_datetime: mismatch");
    $finish;
  end

endmodule
